// ===== sv/kdlp_pkg.sv =====
`default_nettype none
package kdlp_pkg;

  localparam int unsigned NUM_KEYS  = 8;
  localparam int unsigned OUT_KEYS  = (NUM_KEYS < 8) ? NUM_KEYS : 8;
  localparam int unsigned MASK_W    = 8;

  localparam int unsigned FT_W      = 7;
  localparam int unsigned LT_W      = 16;
  localparam int unsigned RS_W      = 8;
  localparam int unsigned CNT_W     = 8;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 16;

  localparam logic [FT_W-1:0]  FILTER_RESET = FT_W'(5);
  localparam logic [LT_W-1:0]  LONG_RESET   = LT_W'(50);
  localparam logic [RS_W-1:0]  REPEAT_RESET = '0;
  localparam logic [CNT_W-1:0] COUNT_RESET  = CNT_W'(5 / 2);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FILTER_TIME  = 2'd0,
    REG_LONG_TIME    = 2'd1,
    REG_REPEAT_SPEED = 2'd2,
    REG_UNUSED       = 2'd3
  } kdlp_reg_t;

  typedef struct packed {
    logic [FT_W-1:0] filter_time;
    logic [LT_W-1:0] long_time;
    logic [RS_W-1:0] repeat_speed;
  } kdlp_cfg_t;

  typedef struct packed {
    logic down;
    logic up;
    logic long_ev;
    logic rpt;
    logic level;
  } kdlp_flags_t;

endpackage
`default_nettype wire

// ===== sv/kdlp_lane.sv =====
`default_nettype none
module kdlp_lane (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   step,
  input  wire logic                   raw,
  input  wire kdlp_pkg::kdlp_cfg_t    cfg,
  output kdlp_pkg::kdlp_flags_t       flags
);

  logic [kdlp_pkg::CNT_W-1:0] fc_r, fc_nxt;
  logic                       ps_r, ps_nxt;
  logic [kdlp_pkg::LT_W-1:0]  hold_r, hold_nxt;
  logic [kdlp_pkg::RS_W-1:0]  rep_r, rep_nxt;

  logic [kdlp_pkg::CNT_W-1:0] ft8;
  logic [kdlp_pkg::CNT_W-1:0] top2;
  logic [kdlp_pkg::LT_W-1:0]  hold_inc;
  logic [kdlp_pkg::RS_W-1:0]  rep_inc;

  assign ft8      = {1'b0, cfg.filter_time};
  assign top2     = {cfg.filter_time, 1'b0};
  assign hold_inc = hold_r + kdlp_pkg::LT_W'(1);
  assign rep_inc  = rep_r + kdlp_pkg::RS_W'(1);

  always_comb begin
    fc_nxt   = fc_r;
    ps_nxt   = ps_r;
    hold_nxt = hold_r;
    rep_nxt  = rep_r;
    flags    = '0;
    if (step) begin
      if (raw) begin
        if (fc_r < ft8) begin
          fc_nxt = ft8;
        end else if (fc_r < top2) begin
          fc_nxt = fc_r + kdlp_pkg::CNT_W'(1);
        end else begin
          if (!ps_r) begin
            ps_nxt     = 1'b1;
            flags.down = 1'b1;
          end
          if (cfg.long_time != '0) begin
            if (hold_r < cfg.long_time) begin
              hold_nxt = hold_inc;
              if (hold_inc == cfg.long_time) begin
                flags.long_ev = 1'b1;
              end
            end else if (cfg.repeat_speed != '0) begin
              if (rep_inc >= cfg.repeat_speed) begin
                rep_nxt   = '0;
                flags.rpt = 1'b1;
              end else begin
                rep_nxt = rep_inc;
              end
            end
          end
        end
      end else begin
        if (fc_r > ft8) begin
          fc_nxt = ft8;
        end else if (fc_r != '0) begin
          fc_nxt = fc_r - kdlp_pkg::CNT_W'(1);
        end else if (ps_r) begin
          ps_nxt   = 1'b0;
          flags.up = 1'b1;
        end
        hold_nxt = '0;
        rep_nxt  = '0;
      end
    end
    flags.level = ps_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fc_r   <= kdlp_pkg::COUNT_RESET;
      ps_r   <= 1'b0;
      hold_r <= '0;
      rep_r  <= '0;
    end else begin
      fc_r   <= fc_nxt;
      ps_r   <= ps_nxt;
      hold_r <= hold_nxt;
      rep_r  <= rep_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== sv/kdlp_merge.sv =====
`default_nettype none
module kdlp_merge (
  input  wire logic                                        clk,
  input  wire logic                                        rst_n,
  input  wire logic                                        in_fire,
  input  wire kdlp_pkg::kdlp_flags_t [kdlp_pkg::NUM_KEYS-1:0] lane_flags,
  input  wire logic                                        out_stall,
  output logic                                             out_valid,
  output logic [kdlp_pkg::MASK_W-1:0]                      out_down_events,
  output logic [kdlp_pkg::MASK_W-1:0]                      out_up_events,
  output logic [kdlp_pkg::MASK_W-1:0]                      out_long_events,
  output logic [kdlp_pkg::MASK_W-1:0]                      out_repeat_events,
  output logic [kdlp_pkg::MASK_W-1:0]                      out_key_levels
);

  logic                         valid_r, valid_nxt;
  logic [kdlp_pkg::MASK_W-1:0]  down_r, up_r, long_r, rpt_r, lvl_r;
  logic [kdlp_pkg::MASK_W-1:0]  down_m, up_m, long_m, rpt_m, lvl_m;

  always_comb begin
    down_m = '0;
    up_m   = '0;
    long_m = '0;
    rpt_m  = '0;
    lvl_m  = '0;
    for (int k = 0; k < kdlp_pkg::OUT_KEYS; k++) begin
      down_m[k] = lane_flags[k].down;
      up_m[k]   = lane_flags[k].up;
      long_m[k] = lane_flags[k].long_ev;
      rpt_m[k]  = lane_flags[k].rpt;
      lvl_m[k]  = lane_flags[k].level;
    end
  end

  assign valid_nxt = in_fire | (valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      down_r <= down_m;
      up_r   <= up_m;
      long_r <= long_m;
      rpt_r  <= rpt_m;
      lvl_r  <= lvl_m;
    end
  end

  assign out_valid         = valid_r;
  assign out_down_events   = down_r;
  assign out_up_events     = up_r;
  assign out_long_events   = long_r;
  assign out_repeat_events = rpt_r;
  assign out_key_levels    = lvl_r;

`ifndef SYNTHESIS
  a_down_up_disjoint: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> ((down_r & up_r) == '0))
    else $error("key both down and up in one request");

  a_down_sets_level: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> ((down_r & ~lvl_r) == '0))
    else $error("down event without pressed level");

  a_up_clears_level: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> ((up_r & lvl_r) == '0))
    else $error("up event with pressed level");

  a_hold_events_pressed: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> (((long_r | rpt_r) & ~lvl_r) == '0))
    else $error("long or repeat event on released key");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && !out_stall && !in_fire) |=> !valid_r)
    else $error("output register not drained");
`endif

endmodule
`default_nettype wire

// ===== sv/key_debounce_long_press.sv =====
// Channel | Direction | Handshake          | Payload
// in_     | input     | in_valid/in_stall  | raw_pressed[7:0]
// out_    | output    | out_valid/out_stall| down/up/long/repeat_events, key_levels
// cfg_    | input     | cfg_valid/cfg_ready| cfg_index[1:0], cfg_wdata[15:0]
//
// One request per cycle unless stalled; result in the cycle after acceptance.
// All key lanes update in parallel in the accepting cycle; one output register.
// in_stall only while a result is held and out_stall is high.
// Synchronous active-low reset restores register defaults and key state.
// cfg_ready is always high.
`default_nettype none
module key_debounce_long_press (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [kdlp_pkg::MASK_W-1:0]       in_raw_pressed,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [kdlp_pkg::MASK_W-1:0]            out_down_events,
  output logic [kdlp_pkg::MASK_W-1:0]            out_up_events,
  output logic [kdlp_pkg::MASK_W-1:0]            out_long_events,
  output logic [kdlp_pkg::MASK_W-1:0]            out_repeat_events,
  output logic [kdlp_pkg::MASK_W-1:0]            out_key_levels,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [kdlp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [kdlp_pkg::CFG_DAT_W-1:0]    cfg_wdata
);

  kdlp_pkg::kdlp_cfg_t                           cfg_r;
  kdlp_pkg::kdlp_flags_t [kdlp_pkg::NUM_KEYS-1:0] lane_flags;
  logic                                          in_fire;
  logic [kdlp_pkg::NUM_KEYS-1:0]                 lane_raw;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid & out_stall;
  assign in_fire   = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.filter_time  <= kdlp_pkg::FILTER_RESET;
      cfg_r.long_time    <= kdlp_pkg::LONG_RESET;
      cfg_r.repeat_speed <= kdlp_pkg::REPEAT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (kdlp_pkg::kdlp_reg_t'(cfg_index))
        kdlp_pkg::REG_FILTER_TIME:  cfg_r.filter_time  <= cfg_wdata[kdlp_pkg::FT_W-1:0];
        kdlp_pkg::REG_LONG_TIME:    cfg_r.long_time    <= cfg_wdata[kdlp_pkg::LT_W-1:0];
        kdlp_pkg::REG_REPEAT_SPEED: cfg_r.repeat_speed <= cfg_wdata[kdlp_pkg::RS_W-1:0];
        default: ;
      endcase
    end
  end

  for (genvar k = 0; k < kdlp_pkg::NUM_KEYS; k++) begin : g_lane
    if (k < kdlp_pkg::MASK_W) begin : g_raw
      assign lane_raw[k] = in_raw_pressed[k];
    end else begin : g_zero
      assign lane_raw[k] = 1'b0;
    end

    kdlp_lane u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .step  (in_fire),
      .raw   (lane_raw[k]),
      .cfg   (cfg_r),
      .flags (lane_flags[k])
    );
  end

  kdlp_merge u_merge (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_fire           (in_fire),
    .lane_flags        (lane_flags),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_down_events   (out_down_events),
    .out_up_events     (out_up_events),
    .out_long_events   (out_long_events),
    .out_repeat_events (out_repeat_events),
    .out_key_levels    (out_key_levels)
  );

endmodule
`default_nettype wire
